// ===== design/i2cmbx_pkg.sv =====
// shared constants, types and helpers for the i2c target message mailbox
package i2cmbx_pkg;

   // message store geometry
   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(STORE_DEPTH - 1);

   // decoded bus event codes
   typedef enum logic [2:0] {
      CMD_WR_ADDR = 3'd0,
      CMD_WR_DATA = 3'd1,
      CMD_RD_ADDR = 3'd2,
      CMD_RD_DATA = 3'd3,
      CMD_RD_DONE = 3'd4,
      CMD_LOAD    = 3'd5
   } cmd_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // position advance, saturating at the last store entry
   function automatic logic [ADDR_W-1:0] adv_pos(input logic [ADDR_W-1:0] pos);
      logic [ADDR_W-1:0] nxt;
      nxt = (pos == LAST_POS) ? pos : pos + 1'b1;
      return nxt;
   endfunction

endpackage

// ===== design/i2c_target_message_mailbox.sv =====
// i2c target message mailbox: store, positions, lock and result register
//
//   channel  | direction | signals
//   ---------+-----------+----------------------------------------------------------
//   req      | in        | req_valid req_ready req_cmd req_data req_load_index
//   rsp      | out       | rsp_valid rsp_ready rsp_tx_valid rsp_tx_byte
//            |           | rsp_message_done rsp_request_pulse rsp_lock_status
//
// every beat has two steps: accept (store write or store read issue), then
// execute on the registered read data of the store.
// after reset the store is swept to zero, one entry a cycle, over all STORE_DEPTH
// entries (256) with req_ready low.
// a result waits in the output register; a following beat is accepted meanwhile
// and its execute cycle holds until the output register frees.
module i2c_target_message_mailbox (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_data,
   input  logic [7:0] req_load_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_message_done,
   output logic       rsp_request_pulse,
   output logic       rsp_lock_status
);

   localparam int AW = i2cmbx_pkg::ADDR_W;

   // message store
   logic [7:0] mem [i2cmbx_pkg::STORE_DEPTH];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rdata_ff;

   // control state
   i2cmbx_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] rx_pos_ff, rx_pos_in;
   logic [AW-1:0] tx_pos_ff, tx_pos_in;
   logic          locked_ff, locked_in;

   // per-beat flags carried to the execute cycle
   logic op_tx_ff, op_tx_in;
   logic op_req_ff, op_req_in;
   logic op_done_ff, op_done_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_tx_valid_ff, rsp_tx_valid_in;
   logic [7:0] rsp_tx_byte_ff, rsp_tx_byte_in;
   logic       rsp_done_ff, rsp_done_in;
   logic       rsp_req_ff, rsp_req_in;
   logic       rsp_lock_ff, rsp_lock_in;

   logic accept;
   logic commit;
   logic load_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2cmbx_pkg::ST_CLEAR: begin
            if (clr_ff == i2cmbx_pkg::LAST_POS) state_in = i2cmbx_pkg::ST_IDLE;
         end
         i2cmbx_pkg::ST_IDLE: begin
            if (req_valid) state_in = i2cmbx_pkg::ST_EXEC;
         end
         i2cmbx_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) state_in = i2cmbx_pkg::ST_IDLE;
         end
         default: state_in = i2cmbx_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         i2cmbx_pkg::ST_IDLE: req_ready = 1'b1;
         i2cmbx_pkg::ST_EXEC: commit    = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   assign accept  = req_valid && req_ready;
   assign load_ok = 32'(req_load_index) < 32'(i2cmbx_pkg::STORE_DEPTH);

   // clear sweep, store access and position updates at accept, lock release at commit
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = rx_pos_ff;
      wr_data    = req_data;
      rd_en      = 1'b0;
      rd_addr    = tx_pos_ff;
      clr_in     = clr_ff;
      rx_pos_in  = rx_pos_ff;
      tx_pos_in  = tx_pos_ff;
      locked_in  = locked_ff;
      op_tx_in   = op_tx_ff;
      op_req_in  = op_req_ff;
      op_done_in = op_done_ff;

      if (state_ff == i2cmbx_pkg::ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = 8'd0;
         clr_in  = i2cmbx_pkg::adv_pos(clr_ff);
      end

      if (accept) begin
         op_tx_in   = 1'b0;
         op_req_in  = 1'b0;
         op_done_in = 1'b0;
         case (i2cmbx_pkg::cmd_type'(req_cmd))
            i2cmbx_pkg::CMD_WR_ADDR: rx_pos_in = '0;
            i2cmbx_pkg::CMD_WR_DATA: begin
               wr_en      = 1'b1;
               wr_addr    = rx_pos_ff;
               op_done_in = (req_data == 8'd0);
               rx_pos_in  = i2cmbx_pkg::adv_pos(rx_pos_ff);
            end
            i2cmbx_pkg::CMD_RD_ADDR: begin
               rd_en    = 1'b1;
               op_tx_in = 1'b1;
               if (!locked_ff) begin
                  op_req_in = 1'b1;
                  locked_in = 1'b1;
                  tx_pos_in = '0;
                  rd_addr   = '0;
               end else begin
                  rd_addr   = tx_pos_ff;
               end
            end
            i2cmbx_pkg::CMD_RD_DATA: begin
               if (locked_ff) begin
                  rd_en     = 1'b1;
                  op_tx_in  = 1'b1;
                  tx_pos_in = i2cmbx_pkg::adv_pos(tx_pos_ff);
                  rd_addr   = i2cmbx_pkg::adv_pos(tx_pos_ff);
               end
            end
            i2cmbx_pkg::CMD_LOAD: begin
               wr_en   = load_ok;
               wr_addr = AW'(req_load_index);
            end
            default: op_tx_in = 1'b0;
         endcase
      end

      // a sent zero byte ends the transfer
      if (commit && op_tx_ff && rdata_ff == 8'd0) locked_in = 1'b0;
   end

   // result assembly and output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_tx_valid_in = rsp_tx_valid_ff;
      rsp_tx_byte_in  = rsp_tx_byte_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_req_in      = rsp_req_ff;
      rsp_lock_in     = rsp_lock_ff;
      if (commit) begin
         rsp_valid_in    = 1'b1;
         rsp_tx_valid_in = op_tx_ff;
         rsp_tx_byte_in  = op_tx_ff ? rdata_ff : 8'd0;
         rsp_done_in     = op_done_ff;
         rsp_req_in      = op_req_ff;
         rsp_lock_in     = locked_in;
      end
   end

   // store: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2cmbx_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rx_pos_ff    <= '0;
         tx_pos_ff    <= '0;
         locked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rx_pos_ff    <= rx_pos_in;
         tx_pos_ff    <= tx_pos_in;
         locked_ff    <= locked_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_tx_ff        <= op_tx_in;
      op_req_ff       <= op_req_in;
      op_done_ff      <= op_done_in;
      rsp_tx_valid_ff <= rsp_tx_valid_in;
      rsp_tx_byte_ff  <= rsp_tx_byte_in;
      rsp_done_ff     <= rsp_done_in;
      rsp_req_ff      <= rsp_req_in;
      rsp_lock_ff     <= rsp_lock_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_valid      = rsp_tx_valid_ff;
   assign rsp_tx_byte       = rsp_tx_byte_ff;
   assign rsp_message_done  = rsp_done_ff;
   assign rsp_request_pulse = rsp_req_ff;
   assign rsp_lock_status   = rsp_lock_ff;

endmodule

// ===== design/i2cmbx_checker.sv =====
// port-level checks for the i2c target message mailbox, bound to the top level
module i2cmbx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_message_done,
   input logic       rsp_request_pulse,
   input logic       rsp_lock_status
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
         && $stable(rsp_tx_valid) && $stable(rsp_lock_status))
      else $error("result beat changed while stalled");

   // the lock after a send follows whether the sent byte was a terminator
   a_lock_follows_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> (rsp_lock_status == (rsp_tx_byte != 8'd0)))
      else $error("lock status disagrees with sent byte");

   // a read request pulse always comes with a sent byte
   a_req_sends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_pulse |-> rsp_tx_valid)
      else $error("request pulse without a sent byte");

   // a completed message never coincides with a send
   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_done |-> !rsp_tx_valid && !rsp_request_pulse)
      else $error("message done together with a send");

   // the store sweep holds off input beats after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("beat possible right after reset");

endmodule

bind i2c_target_message_mailbox i2cmbx_checker u_i2cmbx_checker (.*);

// ===== test/mailbox_reply_checker.sv =====
// reply checker for the i2c target mailbox: tracks the store and lock, compares every reply beat
module mailbox_reply_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_data,
   input  logic [7:0] req_load_index,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_tx_valid,
   input  logic [7:0] rsp_tx_byte,
   input  logic       rsp_message_done,
   input  logic       rsp_request_pulse,
   input  logic       rsp_lock_status,
   output int         mismatch_count,
   output int         replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       message_done;
      logic       request_pulse;
      logic       lock_status;
   } mailbox_reply_type;

   // shadow copy of the mailbox state
   logic [7:0]                    shadow_store [i2cmbx_pkg::STORE_DEPTH];
   logic [i2cmbx_pkg::ADDR_W-1:0] rx_pos;
   logic [i2cmbx_pkg::ADDR_W-1:0] tx_pos;
   logic                          send_busy;

   mailbox_reply_type reply_queue [$];

   // apply one bus event to the shadow state and return the reply it should produce
   function automatic mailbox_reply_type predict_bus_event(input logic [2:0] cmd,
                                                           input logic [7:0] data,
                                                           input logic [7:0] load_idx);
      mailbox_reply_type r;
      logic [7:0]        b;
      r = '0;
      case (cmd)
         i2cmbx_pkg::CMD_WR_ADDR: begin
            rx_pos = '0;
         end
         i2cmbx_pkg::CMD_WR_DATA: begin
            shadow_store[rx_pos] = data;
            r.message_done = (data == 8'd0);
            if (rx_pos != i2cmbx_pkg::LAST_POS) rx_pos = rx_pos + 1'b1;
         end
         i2cmbx_pkg::CMD_RD_ADDR: begin
            // a fresh read restarts the response only while unlocked
            if (!send_busy) begin
               r.request_pulse = 1'b1;
               send_busy = 1'b1;
               tx_pos = '0;
            end
            b = shadow_store[tx_pos];
            if (b == 8'd0) send_busy = 1'b0;
            r.tx_valid = 1'b1;
            r.tx_byte = b;
         end
         i2cmbx_pkg::CMD_RD_DATA: begin
            if (send_busy) begin
               if (tx_pos != i2cmbx_pkg::LAST_POS) tx_pos = tx_pos + 1'b1;
               b = shadow_store[tx_pos];
               if (b == 8'd0) send_busy = 1'b0;
               r.tx_valid = 1'b1;
               r.tx_byte = b;
            end
         end
         i2cmbx_pkg::CMD_LOAD: begin
            if (int'(load_idx) < i2cmbx_pkg::STORE_DEPTH)
               shadow_store[load_idx[i2cmbx_pkg::ADDR_W-1:0]] = data;
         end
         default: begin
         end
      endcase
      r.lock_status = send_busy;
      return r;
   endfunction

   function automatic int field_differs(input string field, input int want, input int got);
      if (want != got) begin
         $error("reply field %s: expected %0h, got %0h", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // compare reply beats first, then queue the prediction for a request beat
   always @(posedge clock) begin
      mailbox_reply_type want;
      int                bad;
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = 8'd0;
         rx_pos = '0;
         tx_pos = '0;
         send_busy = 1'b0;
         reply_queue.delete();
         mismatch_count <= 0;
         replies_owed <= 0;
      end else begin
         bad = 0;
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               $error("reply beat with no request waiting");
               bad = 1;
            end else begin
               want = reply_queue.pop_front();
               bad += field_differs("tx_valid", want.tx_valid, rsp_tx_valid);
               bad += field_differs("tx_byte", want.tx_byte, rsp_tx_byte);
               bad += field_differs("message_done", want.message_done, rsp_message_done);
               bad += field_differs("request_pulse", want.request_pulse, rsp_request_pulse);
               bad += field_differs("lock_status", want.lock_status, rsp_lock_status);
            end
         end
         if (req_valid && req_ready)
            reply_queue.push_back(predict_bus_event(req_cmd, req_data, req_load_index));
         mismatch_count <= mismatch_count + bad;
         replies_owed <= reply_queue.size();
      end
   end

endmodule

// ===== test/tb.sv =====
// testbench top for the i2c target mailbox: clock, reset, bus event stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BEAT_TARGET = 1450;
   localparam int CYCLE_LIMIT = 200000;
   // event codes the block ignores
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_cmd;
   logic [7:0] req_data;
   logic [7:0] req_load_index;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_message_done;
   logic       rsp_request_pulse;
   logic       rsp_lock_status;

   int mismatch_count;
   int replies_owed;
   int beats_sent;
   int cycle_count;
   bit calm;

   always #5 clock = ~clock;

   i2c_target_message_mailbox u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data          (req_data),
      .req_load_index    (req_load_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_message_done  (rsp_message_done),
      .rsp_request_pulse (rsp_request_pulse),
      .rsp_lock_status   (rsp_lock_status)
   );

   mailbox_reply_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data          (req_data),
      .req_load_index    (req_load_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_tx_valid      (rsp_tx_valid),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_message_done  (rsp_message_done),
      .rsp_request_pulse (rsp_request_pulse),
      .rsp_lock_status   (rsp_lock_status),
      .mismatch_count    (mismatch_count),
      .replies_owed      (replies_owed)
   );

   // reply side backpressure, off during the calm stretch
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // present one bus event beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [2:0] cmd, input logic [7:0] data,
                            input logic [7:0] load_idx);
      if (!calm && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(0, 99) < 27);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_data       <= data;
      req_load_index <= load_idx;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // hold off the sender until every reply is in
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   initial begin
      int roll;
      int n;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= i2cmbx_pkg::CMD_WR_ADDR;
      req_data       <= 8'd0;
      req_load_index <= 8'd0;
      rsp_ready      <= 1'b0;
      cycle_count    <= 0;
      calm           <= 1'b0;
      beats_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, short message, locked reads, ignored events
      send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'h5A, 8'h00);   // read data while unlocked
      send_beat(i2cmbx_pkg::CMD_RD_ADDR, 8'h00, 8'h00);   // read on the cleared store unlocks
      send_beat(i2cmbx_pkg::CMD_WR_ADDR, 8'h00, 8'h00);
      send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'hFF, 8'h00);
      send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'h01, 8'h00);
      send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'h00, 8'h00);   // terminator completes the message
      send_beat(i2cmbx_pkg::CMD_LOAD, 8'hAA, 8'hFF);      // last entry
      send_beat(i2cmbx_pkg::CMD_LOAD, 8'h80, 8'h00);
      send_beat(i2cmbx_pkg::CMD_RD_ADDR, 8'h00, 8'h00);
      send_beat(i2cmbx_pkg::CMD_RD_ADDR, 8'h00, 8'h00);   // repeat read while locked
      send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'h00, 8'h00);
      send_beat(i2cmbx_pkg::CMD_RD_DONE, 8'hFF, 8'hFF);
      send_beat(CMD_SPARE_A, 8'h00, 8'h00);
      send_beat(CMD_SPARE_B, 8'hFF, 8'hFF);
      send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'h00, 8'h00);   // zero byte ends the transfer
      send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'h00, 8'h00);
      send_beat(i2cmbx_pkg::CMD_LOAD, 8'h00, 8'h55);
      send_beat(i2cmbx_pkg::CMD_WR_ADDR, 8'hFF, 8'hFF);
      send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'h00, 8'h00);   // message of only a terminator
      drain_replies();

      // overrun the receive position past the end of the store
      send_beat(i2cmbx_pkg::CMD_WR_ADDR, 8'h00, 8'h00);
      for (int i = 0; i < i2cmbx_pkg::STORE_DEPTH + 1; i++)
         send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'($urandom_range(1, 255)), 8'($urandom));
      // read the whole store and keep resending the last entry, no idling here
      calm <= 1'b1;
      send_beat(i2cmbx_pkg::CMD_RD_ADDR, 8'($urandom), 8'($urandom));
      for (int i = 0; i < i2cmbx_pkg::STORE_DEPTH + 2; i++)
         send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'($urandom), 8'($urandom));
      calm <= 1'b0;
      send_beat(i2cmbx_pkg::CMD_LOAD, 8'h00, 8'hFF);
      send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'h00, 8'h00);
      send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'h00, 8'h00);   // terminator at the saturated position

      // random bus traffic, mostly well-formed transfers
      while (beats_sent < BEAT_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            // master write of a short message
            send_beat(i2cmbx_pkg::CMD_WR_ADDR, 8'($urandom), 8'($urandom));
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
               send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'($urandom_range(1, 255)), 8'($urandom));
            if ($urandom_range(0, 99) < 85)
               send_beat(i2cmbx_pkg::CMD_WR_DATA, 8'h00, 8'($urandom));
         end else if (roll < 55) begin
            // local load of a response, sometimes at a random place
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
               send_beat(i2cmbx_pkg::CMD_LOAD, 8'($urandom_range(1, 255)), 8'(i));
            if ($urandom_range(0, 99) < 80)
               send_beat(i2cmbx_pkg::CMD_LOAD, 8'h00, 8'(n));
            else
               send_beat(i2cmbx_pkg::CMD_LOAD, 8'($urandom), 8'($urandom));
         end else if (roll < 85) begin
            // master read of a response
            send_beat(i2cmbx_pkg::CMD_RD_ADDR, 8'($urandom), 8'($urandom));
            n = $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
               send_beat(i2cmbx_pkg::CMD_RD_DATA, 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 99) < 70)
               send_beat(i2cmbx_pkg::CMD_RD_DONE, 8'($urandom), 8'($urandom));
         end else if (roll < 97) begin
            // noise: any code, any payload
            send_beat(3'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom),
                      8'($urandom));
         end else begin
            drain_replies();
         end
      end

      // let the last replies come home, then give the verdict
      drain_replies();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
